>>> src/aes_cfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aes_cfb_pkg;

	localparam int unsigned NumRounds = 14;
	localparam int unsigned RkWords = 60;
	localparam int unsigned RkIdxW = 6;
	localparam int unsigned RoundW = 4;

	// configuration register indexes
	localparam logic [2:0] REG_KEY0 = 3'd0;
	localparam logic [2:0] REG_KEY1 = 3'd1;
	localparam logic [2:0] REG_KEY2 = 3'd2;
	localparam logic [2:0] REG_KEY3 = 3'd3;
	localparam logic [2:0] REG_DIR  = 3'd4;

	typedef logic [7:0] byte_t;
	typedef logic [31:0] word_t;
	typedef logic [127:0] block_t;

	function automatic byte_t sbox(input byte_t a);
		byte_t r;
		case (a)
			8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
			8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
			8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
			8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
			8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
			8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
			8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
			8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
			8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
			8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
			8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
			8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
			8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
			8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
			8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
			8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
			8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
			8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
			8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
			8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
			8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
			8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
			8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
			8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
			8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
			8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
			8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
			8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
			8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
			8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
			8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
			8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
			8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
			8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
			8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
			8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
			8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
			8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
			8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
			8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
			8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
			8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
			8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
			8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
			8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
			8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
			8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
			8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
			8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
			8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
			8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
			8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
			8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
			8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
			8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
			8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
			8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
			8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
			8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
			8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
			8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
			8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
			8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
			8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic word_t sub_word(input word_t w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	function automatic byte_t xtime(input byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// bytes of the block: byte 0 in bits 127:120
	function automatic byte_t blk_byte(input block_t b, input logic [3:0] i);
		return b[8'd127 - {i, 3'b000} -: 8];
	endfunction

	// one round without the key addition: sub bytes, shift rows, optional mix columns
	function automatic block_t aes_round(input block_t s, input logic mix);
		block_t t;
		block_t o;
		byte_t a0, a1, a2, a3, all;
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				t[127 - 8 * (4 * c + i) -: 8] =
					sbox(s[127 - 8 * (4 * ((c + i) % 4) + i) -: 8]);
			end
		end
		o = t;
		if (mix) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[127 - 32 * c -: 8];
				a1 = t[119 - 32 * c -: 8];
				a2 = t[111 - 32 * c -: 8];
				a3 = t[103 - 32 * c -: 8];
				all = a0 ^ a1 ^ a2 ^ a3;
				o[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
				o[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
				o[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
				o[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
			end
		end
		return o;
	endfunction

endpackage
`default_nettype wire

>>> src/aes256_cfb_byte_stream.sv
`timescale 1ns / 1ps
`default_nettype none
// byte path: the input byte is registered as pending, then xored with the keystream into the output register
// a byte that opens a new block first waits for the 14-round cipher
// key expansion after reset or a key write: one key word per cycle, then the cipher
// one byte at a time: a new input byte is taken only after the last one has left the output
// reset clears keys and direction and runs expansion and cipher of the zero block
module aes256_cfb_byte_stream (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte
);
	import aes_cfb_pkg::*;

	localparam logic [2:0] ST_EXPAND = 3'd0;
	localparam logic [2:0] ST_CIPHER = 3'd1;
	localparam logic [2:0] ST_IDLE   = 3'd2;
	localparam logic [2:0] ST_OUT    = 3'd3;

	logic [2:0]        state_q;
	logic [255:0]      key_q;
	logic              dir_q;
	block_t            rk_q [NumRounds + 1];
	logic [RkIdxW-1:0] exp_idx_q;
	logic [RoundW-1:0] round_q;
	block_t            fb_q;
	block_t            st_q;
	logic [4:0]        pos_q;
	logic              pend_q;
	byte_t             pend_byte_q;
	byte_t             out_q;
	logic [2:0]        rcon_idx;
	logic              key_wr;

	// key expansion: one word per cycle
	logic [RkIdxW-1:0] prev_idx, back_idx;
	word_t exp_prev, exp_back, exp_t, exp_word;
	byte_t exp_rcon;
	always_comb begin
		prev_idx = exp_idx_q - 6'd1;
		back_idx = exp_idx_q - 6'd8;
		exp_prev = rk_q[prev_idx[5:2]][8'd127 - {prev_idx[1:0], 5'b00000} -: 32];
		exp_back = rk_q[back_idx[5:2]][8'd127 - {back_idx[1:0], 5'b00000} -: 32];
		rcon_idx = exp_idx_q[5:3] - 3'd1;
		exp_rcon = 8'h01 << rcon_idx;
		exp_t = exp_prev;
		if (exp_idx_q[2:0] == 3'd0) begin
			exp_t = sub_word({exp_prev[23:0], exp_prev[31:24]}) ^ {exp_rcon, 24'h0};
		end else if (exp_idx_q[2:0] == 3'd4) begin
			exp_t = sub_word(exp_prev);
		end
		exp_word = exp_back ^ exp_t;
	end

	// shared round unit
	block_t rnd_out, rnd_key;
	always_comb begin
		rnd_key = rk_q[round_q];
		rnd_out = aes_round(st_q, round_q != 4'(NumRounds)) ^ rnd_key;
	end

	logic [3:0] bpos;
	byte_t      ks_out;
	assign bpos   = pos_q[3:0];
	assign ks_out = pend_byte_q ^ blk_byte(fb_q, bpos);

	assign key_wr = cfg_we && (cfg_index == REG_KEY0 || cfg_index == REG_KEY1 ||
		cfg_index == REG_KEY2 || cfg_index == REG_KEY3);

	assign in_ready  = (state_q == ST_IDLE) && !pend_q;
	assign out_valid = (state_q == ST_OUT);
	assign out_byte  = out_q;

	// round key store: one 128-bit entry per round, filled a word at a time
	always_ff @(posedge clk) begin
		if (state_q == ST_EXPAND && exp_idx_q >= 6'd8) begin
			rk_q[exp_idx_q[5:2]][8'd127 - {exp_idx_q[1:0], 5'b00000} -: 32] <= exp_word;
		end else if (state_q == ST_EXPAND) begin
			rk_q[exp_idx_q[5:2]][8'd127 - {exp_idx_q[1:0], 5'b00000} -: 32] <=
				key_q[255 - 32 * exp_idx_q[2:0] -: 32];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_EXPAND;
			key_q       <= '0;
			dir_q       <= 1'b0;
			exp_idx_q   <= '0;
			round_q     <= '0;
			pos_q       <= '0;
			pend_q      <= 1'b0;
			pend_byte_q <= '0;
			out_q       <= '0;
			fb_q        <= '0;
			st_q        <= '0;
		end else begin
			if (key_wr) begin
				// new key: expand again and restart the stream
				state_q   <= ST_EXPAND;
				exp_idx_q <= '0;
			end else begin
				unique case (state_q)
					ST_EXPAND: begin
						exp_idx_q <= exp_idx_q + 6'd1;
						if (exp_idx_q == 6'(RkWords - 1)) begin
							state_q <= ST_CIPHER;
							round_q <= '0;
							st_q    <= '0;
							pos_q   <= '0;
						end
					end
					ST_CIPHER: begin
						if (round_q == 4'd0) begin
							st_q <= st_q ^ rk_q[0];
						end else begin
							st_q <= rnd_out;
						end
						round_q <= round_q + 4'd1;
						if (round_q == 4'(NumRounds)) begin
							fb_q    <= rnd_out;
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (in_valid && in_ready) begin
							pend_q      <= 1'b1;
							pend_byte_q <= data_byte;
						end
						if (pend_q) begin
							if (pos_q[4]) begin
								// block used up: encrypt feedback first
								st_q    <= fb_q;
								pos_q   <= '0;
								round_q <= '0;
								state_q <= ST_CIPHER;
							end else begin
								out_q <= ks_out;
								fb_q[8'd127 - {bpos, 3'b000} -: 8] <=
									dir_q ? pend_byte_q : ks_out;
								pos_q   <= pos_q + 5'd1;
								pend_q  <= 1'b0;
								state_q <= ST_OUT;
							end
						end
					end
					ST_OUT: begin
						if (out_ready) begin
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY0: key_q[255:192] <= cfg_data;
					REG_KEY1: key_q[191:128] <= cfg_data;
					REG_KEY2: key_q[127:64]  <= cfg_data;
					REG_KEY3: key_q[63:0]    <= cfg_data;
					REG_DIR:  dir_q          <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	a_out_one_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> !out_valid)
		else $error("output held past handshake");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 5'd16)
		else $error("byte position overflow");
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CIPHER || state_q == ST_EXPAND) |-> !in_ready)
		else $error("input accepted during cipher");
	a_out_after_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pend_q))
		else $error("output without pending byte");

endmodule
`default_nettype wire

>>> verif/aes256_cfb_byte_stream_tb.sv
`timescale 1ns / 1ps
module aes256_cfb_byte_stream_tb;
	import aes_cfb_pkg::*;

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned SettleCycles = 120;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [7:0] data_byte;
	logic out_valid;
	logic out_ready;
	logic [7:0] out_byte;

	aes256_cfb_byte_stream uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte)
	);

	// cipher state held by the predictor
	logic [63:0] key_regs [4];
	logic decrypt_mode;
	word_t sched [60];
	byte_t feedback [16];
	int unsigned fb_pos;

	byte_t expected_bytes [$];
	int unsigned error_count;
	int unsigned beats_in;
	int unsigned beats_out;
	int unsigned blocks_seen;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_cycles;
	longint unsigned cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// byte-level s-box built from the field inverse and affine map
	function automatic byte_t gf_mul(input byte_t a, input byte_t b);
		byte_t p;
		byte_t x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				p ^= x;
			x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	function automatic byte_t subst(input byte_t a);
		byte_t inv;
		byte_t r;
		inv = 8'h00;
		if (a != 8'h00) begin
			for (int c = 1; c < 256; c++)
				if (gf_mul(a, byte_t'(c)) == 8'h01)
					inv = byte_t'(c);
		end
		r = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
			^ {inv[3:0], inv[7:4]} ^ 8'h63;
		return r;
	endfunction

	byte_t sb_lut [256];

	function automatic word_t sub4(input word_t w);
		return {sb_lut[w[31:24]], sb_lut[w[23:16]], sb_lut[w[15:8]], sb_lut[w[7:0]]};
	endfunction

	function automatic byte_t dbl(input byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	task automatic expand_schedule();
		word_t t;
		byte_t rc;
		rc = 8'h01;
		for (int i = 0; i < 8; i++)
			sched[i] = (i % 2 == 0) ? key_regs[i / 2][63:32] : key_regs[i / 2][31:0];
		for (int i = 8; i < 60; i++) begin
			t = sched[i - 1];
			if (i % 8 == 0) begin
				t = sub4({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = dbl(rc);
			end else if (i % 8 == 4) begin
				t = sub4(t);
			end
			sched[i] = sched[i - 8] ^ t;
		end
	endtask

	function automatic void add_key(inout byte_t s [16], input int r);
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				s[4 * c + i] ^= sched[4 * r + c][31 - 8 * i -: 8];
	endfunction

	function automatic void cipher_feedback();
		byte_t t [16];
		byte_t a0, a1, a2, a3, all;
		add_key(feedback, 0);
		for (int r = 1; r <= 14; r++) begin
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++)
					t[4 * c + i] = sb_lut[feedback[4 * ((c + i) % 4) + i]];
			if (r != 14) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
					all = a0 ^ a1 ^ a2 ^ a3;
					feedback[4 * c] = a0 ^ all ^ dbl(a0 ^ a1);
					feedback[4 * c + 1] = a1 ^ all ^ dbl(a1 ^ a2);
					feedback[4 * c + 2] = a2 ^ all ^ dbl(a2 ^ a3);
					feedback[4 * c + 3] = a3 ^ all ^ dbl(a3 ^ a0);
				end
			end else begin
				feedback = t;
			end
			add_key(feedback, r);
		end
	endfunction

	task automatic restart_keystream();
		expand_schedule();
		for (int i = 0; i < 16; i++)
			feedback[i] = 8'h00;
		cipher_feedback();
		fb_pos = 0;
	endtask

	// next keystream byte and feedback update for one input byte
	function automatic byte_t predict_out_byte(input byte_t b);
		byte_t o;
		if (fb_pos >= 16) begin
			cipher_feedback();
			fb_pos = 0;
			blocks_seen++;
		end
		o = b ^ feedback[fb_pos];
		feedback[fb_pos] = decrypt_mode ? b : o;
		fb_pos++;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input byte_t got, input byte_t want);
		$display("mismatch at output beat %0d: %s got %02h expected %02h",
			beats_out, what, got, want);
		error_count++;
	endtask

	// cycle counter and timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// output beat checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch("unexpected beat, out_byte", out_byte, 8'h00);
			end else begin
				if (out_byte !== expected_bytes[0])
					report_mismatch("out_byte", out_byte, expected_bytes[0]);
				void'(expected_bytes.pop_front());
			end
			beats_out++;
		end
	end

	task automatic send_byte(input byte_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_bytes.push_back(predict_out_byte(b));
		beats_in++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DIR) begin
			decrypt_mode = val[0];
		end else if (idx <= REG_KEY3) begin
			key_regs[idx] = val;
			restart_keystream();
		end
		@(posedge clk);
	endtask

	task automatic load_key(input logic [63:0] k0, k1, k2, k3);
		write_reg(REG_KEY0, k0);
		write_reg(REG_KEY1, k1);
		write_reg(REG_KEY2, k2);
		write_reg(REG_KEY3, k3);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// zero key after reset, byte extremes, block boundary, both directions
	task automatic test_directed();
		send_byte(8'h00);
		send_byte(8'hff);
		for (int i = 0; i < 15; i++)
			send_byte(8'h55 << (i % 2));
		wait_drained();
		// direction change in the middle of a block keeps the stream position
		write_reg(REG_DIR, 64'h1);
		send_byte(8'h80);
		send_byte(8'h01);
		wait_drained();
		write_reg(REG_DIR, 64'h0);
		load_key('1, '1, '1, '1);
		send_byte(8'hff);
		send_byte(8'h00);
		wait_drained();
		// out-of-range index must be ignored
		write_reg(3'd7, 64'hdead_beef_0123_4567);
		write_reg(3'd5, '1);
		send_byte(8'haa);
		wait_drained();
	endtask

	task automatic test_random_stream(input int unsigned n_bytes, input logic dir);
		write_reg(REG_DIR, {63'h0, dir});
		load_key({$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});
		for (int i = 0; i < n_bytes; i++)
			send_byte(byte_t'($urandom_range(255)));
		wait_drained();
	endtask

	// sink blocked for a long stretch while bytes keep arriving
	task automatic test_backpressure();
		hold_cycles = 300;
		for (int i = 0; i < 40; i++)
			send_byte(byte_t'($urandom_range(255)));
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < 256; i++)
			sb_lut[i] = subst(byte_t'(i));
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY0;
		cfg_data = '0;
		in_valid = 1'b0;
		data_byte = '0;
		out_ready = 1'b0;
		error_count = 0;
		beats_in = 0;
		beats_out = 0;
		blocks_seen = 0;
		hold_cycles = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 4; i++)
			key_regs[i] = '0;
		decrypt_mode = 1'b0;
		restart_keystream();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (SettleCycles) @(posedge clk);

		test_directed();
		send_idle_pct = 20;
		recv_idle_pct = 66;
		test_random_stream(150, 1'b0);
		test_random_stream(150, 1'b1);
		send_idle_pct = 66;
		recv_idle_pct = 20;
		test_random_stream(150, 1'b0);
		test_random_stream(150, 1'b1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_random_stream(150, 1'b1);
		test_random_stream(150, 1'b0);
		wait_drained();

		$display("%0d bytes in, %0d bytes out, %0d keystream refills",
			beats_in, beats_out, blocks_seen);
		$display("several keys, both directions, stalls on both sides");
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d errors", error_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
